FILE: hw/rtl/cpio_nes_pkg.sv
// Shared types, constants and helper functions of the cpio newc entry scanner.
`timescale 1ns / 1ps

package cpio_nes_pkg;

	localparam int unsigned HEADER_BYTES   = 110;
	localparam int unsigned MAX_NAME_BYTES = 16;
	localparam int unsigned FSIZE_FIRST    = 54;
	localparam int unsigned NSIZE_FIRST    = 94;
	localparam int unsigned HEX_DIGITS     = 8;
	localparam int unsigned TRAILER_LEN    = 10;

	// configuration register indexes
	localparam logic [1:0] REG_TARGET_LOW  = 2'd0;
	localparam logic [1:0] REG_TARGET_HIGH = 2'd1;
	localparam logic [1:0] REG_TARGET_LEN  = 2'd2;

	typedef struct packed {
		logic [63:0] target_low;
		logic [63:0] target_high;
		logic [4:0]  target_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] archive_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [15:0] entry_index;
		logic [31:0] name_size;
		logic [31:0] file_bytes;
		logic [31:0] data_offset;
		logic        is_match;
		logic        is_trailer;
	} record_t;

	// non-hex characters count as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= "0" && c <= "9") begin
			d = c - 8'h30;
		end else if (c >= "A" && c <= "F") begin
			d = c - 8'h37;
		end else if (c >= "a" && c <= "f") begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] p);
		logic [7:0] ch;
		unique case (p)
			4'd0:    ch = "T";
			4'd1:    ch = "R";
			4'd2:    ch = "A";
			4'd3:    ch = "I";
			4'd4:    ch = "L";
			4'd5:    ch = "E";
			4'd6:    ch = "R";
			4'd7:    ch = "!";
			4'd8:    ch = "!";
			4'd9:    ch = "!";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/cpio_nes_cfg.sv
// Configuration registers: target name and its length.
`timescale 1ns / 1ps

module cpio_nes_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [63:0]         wr_data,
	output cpio_nes_pkg::cfg_t  cfg
);

	cpio_nes_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				cpio_nes_pkg::REG_TARGET_LOW:  cfg_q.target_low  <= wr_data;
				cpio_nes_pkg::REG_TARGET_HIGH: cfg_q.target_high <= wr_data;
				cpio_nes_pkg::REG_TARGET_LEN:  cfg_q.target_len  <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/cpio_nes_in.sv
// Input register stage for archive bytes.
`timescale 1ns / 1ps

module cpio_nes_in (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 archive_valid,
	input  logic [7:0]           archive_byte,
	input  logic                 restart,
	output logic                 archive_stall,
	input  logic                 advance,
	output logic                 valid_s1,
	output cpio_nes_pkg::item_t  item_s1
);

	logic                accept;
	cpio_nes_pkg::item_t data_s1;
	logic                full_s1;

	assign archive_stall = full_s1 && !advance;
	assign accept        = archive_valid && !archive_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_s1 <= 1'b0;
		end else if (accept) begin
			full_s1 <= 1'b1;
		end else if (advance) begin
			full_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.archive_byte <= archive_byte;
			data_s1.restart      <= restart;
		end
	end

	assign valid_s1 = full_s1;
	assign item_s1  = data_s1;

endmodule

FILE: hw/rtl/cpio_nes_parser.sv
// Parser state machine: header fields, name compare, skip counting, record build.
`timescale 1ns / 1ps

module cpio_nes_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  cpio_nes_pkg::item_t    item,
	input  cpio_nes_pkg::cfg_t     cfg,
	output logic                   res_valid,
	output cpio_nes_pkg::record_t  res
);

	typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_SKIP, PH_DONE} phase_t;

	localparam logic [6:0]  HdrLast  = 7'(cpio_nes_pkg::HEADER_BYTES - 1);
	localparam logic [6:0]  FsFirst  = 7'(cpio_nes_pkg::FSIZE_FIRST);
	localparam logic [6:0]  FsEnd    = 7'(cpio_nes_pkg::FSIZE_FIRST + cpio_nes_pkg::HEX_DIGITS);
	localparam logic [6:0]  NsFirst  = 7'(cpio_nes_pkg::NSIZE_FIRST);
	localparam logic [6:0]  NsEnd    = 7'(cpio_nes_pkg::NSIZE_FIRST + cpio_nes_pkg::HEX_DIGITS);
	localparam logic [31:0] TrLen    = 32'(cpio_nes_pkg::TRAILER_LEN);
	localparam logic [31:0] MaxName  = 32'(cpio_nes_pkg::MAX_NAME_BYTES);
	localparam logic [4:0]  MaxName5 = 5'(cpio_nes_pkg::MAX_NAME_BYTES);
	localparam logic [32:0] HdrRnd   = 33'(cpio_nes_pkg::HEADER_BYTES + 3);
	localparam logic [1:0]  HdrLo    = 2'(cpio_nes_pkg::HEADER_BYTES % 4);

	phase_t      phase_q, phase_n, cur_phase;
	logic [6:0]  hpos_q, hpos_n, cur_hpos;
	logic [31:0] ns_q, ns_n, cur_ns;
	logic [31:0] fs_q, fs_n, cur_fs;
	logic [33:0] skip_q, skip_n, cur_skip;
	logic [31:0] npos_q, npos_n, cur_npos;
	logic        tm_q, tm_n, cur_tm;
	logic        trm_q, trm_n, cur_trm;
	logic [15:0] ecnt_q, ecnt_n, cur_ecnt;
	logic [31:0] bpos_q, bpos_n, cur_bpos;
	logic [31:0] est_q, est_n, cur_est;
	// data offset and post-name skip length, settled during the header
	logic [31:0] off_q, off_n;
	logic [33:0] skpre_q, skpre_n;

	logic [15:0][7:0] tgt;
	logic [7:0]       b;
	logic [31:0]      tlen32;
	logic             fin;
	logic             match, trail;
	logic [32:0]      head_rnd;
	logic [33:0]      off_sum;
	logic [1:0]       pad;

	assign tgt    = {cfg.target_high, cfg.target_low};
	assign b      = item.archive_byte;
	assign tlen32 = {27'd0, cfg.target_len};

	// restart clears the parser before this byte is taken
	always_comb begin
		if (item.restart) begin
			cur_phase = PH_HEADER;
			cur_hpos  = '0;
			cur_ns    = '0;
			cur_fs    = '0;
			cur_skip  = '0;
			cur_npos  = '0;
			cur_tm    = 1'b1;
			cur_trm   = 1'b1;
			cur_ecnt  = '0;
			cur_bpos  = '0;
			cur_est   = '0;
		end else begin
			cur_phase = phase_q;
			cur_hpos  = hpos_q;
			cur_ns    = ns_q;
			cur_fs    = fs_q;
			cur_skip  = skip_q;
			cur_npos  = npos_q;
			cur_tm    = tm_q;
			cur_trm   = trm_q;
			cur_ecnt  = ecnt_q;
			cur_bpos  = bpos_q;
			cur_est   = est_q;
		end
	end

	always_comb begin
		head_rnd = ({1'b0, cur_ns} + HdrRnd) & ~33'd3;
		off_sum  = {1'b0, head_rnd} + {2'd0, cur_est};
		pad      = 2'(2'd0 - (cur_ns[1:0] + HdrLo));
		off_n    = (off_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : off_sum[31:0];
		skpre_n  = {32'd0, pad} + (({2'd0, cur_fs} + 34'd3) & ~34'd3);
	end

	always_comb begin
		phase_n = cur_phase;
		hpos_n  = cur_hpos;
		ns_n    = cur_ns;
		fs_n    = cur_fs;
		skip_n  = cur_skip;
		npos_n  = cur_npos;
		tm_n    = cur_tm;
		trm_n   = cur_trm;
		ecnt_n  = cur_ecnt;
		est_n   = cur_est;
		fin     = 1'b0;
		bpos_n  = (cur_bpos != 32'hFFFF_FFFF) ? cur_bpos + 32'd1 : cur_bpos;

		unique case (cur_phase)
			PH_HEADER: begin
				if (cur_hpos == 7'd0) begin
					est_n = cur_bpos;
					ns_n  = '0;
					fs_n  = '0;
				end
				if (cur_hpos >= FsFirst && cur_hpos < FsEnd) begin
					fs_n = {fs_n[27:0], cpio_nes_pkg::hex_value(b)};
				end
				if (cur_hpos >= NsFirst && cur_hpos < NsEnd) begin
					ns_n = {ns_n[27:0], cpio_nes_pkg::hex_value(b)};
				end
				if (cur_hpos >= HdrLast) begin
					hpos_n = '0;
					npos_n = '0;
					tm_n   = 1'b1;
					trm_n  = 1'b1;
					if (ns_n == 32'd0) begin
						fin = 1'b1;
					end else begin
						phase_n = PH_NAME;
					end
				end else begin
					hpos_n = cur_hpos + 7'd1;
				end
			end
			PH_NAME: begin
				if (cur_npos < tlen32 && cur_npos < MaxName) begin
					if (b != tgt[cur_npos[3:0]]) begin
						tm_n = 1'b0;
					end
				end else if (cur_npos == tlen32) begin
					if (b != 8'h00) begin
						tm_n = 1'b0;
					end
				end
				if (cur_npos < TrLen) begin
					if (b != cpio_nes_pkg::trailer_char(cur_npos[3:0])) begin
						trm_n = 1'b0;
					end
				end else if (cur_npos == TrLen) begin
					if (b != 8'h00) begin
						trm_n = 1'b0;
					end
				end
				npos_n = cur_npos + 32'd1;
				fin    = (npos_n >= cur_ns);
			end
			PH_SKIP: begin
				skip_n = (cur_skip != 34'd0) ? cur_skip - 34'd1 : 34'd0;
				if (skip_n == 34'd0) begin
					phase_n = PH_HEADER;
				end
			end
			PH_DONE: ;
			default: ;
		endcase

		match = tm_n && (cfg.target_len <= MaxName5) && (ns_n > tlen32);
		trail = trm_n && (ns_n > TrLen);

		res.entry_index = cur_ecnt;
		res.name_size   = ns_n;
		res.file_bytes  = fs_n;
		res.data_offset = off_q;
		res.is_match    = match;
		res.is_trailer  = trail;
		res_valid       = fin;

		if (fin) begin
			if (cur_ecnt != 16'hFFFF) begin
				ecnt_n = cur_ecnt + 16'd1;
			end
			if (trail) begin
				phase_n = PH_DONE;
			end else begin
				skip_n  = skpre_q;
				phase_n = (skpre_q != 34'd0) ? PH_SKIP : PH_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q  <= '0;
			ns_q    <= '0;
			fs_q    <= '0;
			skip_q  <= '0;
			npos_q  <= '0;
			tm_q    <= 1'b1;
			trm_q   <= 1'b1;
			ecnt_q  <= '0;
			bpos_q  <= '0;
			est_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hpos_q  <= hpos_n;
			ns_q    <= ns_n;
			fs_q    <= fs_n;
			skip_q  <= skip_n;
			npos_q  <= npos_n;
			tm_q    <= tm_n;
			trm_q   <= trm_n;
			ecnt_q  <= ecnt_n;
			bpos_q  <= bpos_n;
			est_q   <= est_n;
		end
	end

	// refreshed on every header byte; final well before the last header byte
	always_ff @(posedge clk) begin
		if (step && cur_phase == PH_HEADER) begin
			off_q   <= off_n;
			skpre_q <= skpre_n;
		end
	end

endmodule

FILE: hw/rtl/cpio_nes_out.sv
// Output record register.
`timescale 1ns / 1ps

module cpio_nes_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  cpio_nes_pkg::record_t  res,
	input  logic                   record_stall,
	output logic                   record_valid,
	output cpio_nes_pkg::record_t  rec
);

	logic                  valid_q;
	cpio_nes_pkg::record_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!record_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= res;
		end
	end

	assign record_valid = valid_q;
	assign rec          = rec_q;

endmodule

FILE: hw/rtl/cpio_newc_entry_scanner_top.sv
// Top level of the cpio newc entry scanner.
//
//  channel   dir  handshake               payload
//  archive   in   archive_valid/_stall    archive_byte, restart
//  record    out  record_valid/_stall     entry_index, name_size, file_bytes,
//                                          data_offset, is_match, is_trailer
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One archive byte per clock unless a held record stalls it. A record leaves after the byte
// completing the name: input register, then parser logic into the record register.
// Reset clears parser state and all three configuration registers; cfg_ready is always high.
// A stalled record holds the parser; one byte more is taken into the input register.
`timescale 1ns / 1ps

module cpio_newc_entry_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        archive_valid,
	output logic        archive_stall,
	input  logic [7:0]  archive_byte,
	input  logic        restart,
	output logic        record_valid,
	input  logic        record_stall,
	output logic [15:0] entry_index,
	output logic [31:0] name_size,
	output logic [31:0] file_bytes,
	output logic [31:0] data_offset,
	output logic        is_match,
	output logic        is_trailer,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cpio_nes_pkg::cfg_t    cfg;
	cpio_nes_pkg::item_t   item_s1;
	cpio_nes_pkg::record_t res;
	cpio_nes_pkg::record_t rec;
	logic                  valid_s1;
	logic                  advance;
	logic                  step;
	logic                  res_valid;

	assign cfg_ready = 1'b1;
	assign advance   = !record_valid || !record_stall;
	assign step      = valid_s1 && advance;

	cpio_nes_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	cpio_nes_in u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.archive_valid (archive_valid),
		.archive_byte  (archive_byte),
		.restart       (restart),
		.archive_stall (archive_stall),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	cpio_nes_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	cpio_nes_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && res_valid),
		.res          (res),
		.record_stall (record_stall),
		.record_valid (record_valid),
		.rec          (rec)
	);

	assign entry_index = rec.entry_index;
	assign name_size   = rec.name_size;
	assign file_bytes  = rec.file_bytes;
	assign data_offset = rec.data_offset;
	assign is_match    = rec.is_match;
	assign is_trailer  = rec.is_trailer;

	// input side only backs up behind a held record
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		archive_stall |-> (valid_s1 && record_valid && record_stall))
		else $error("archive stalled without a held record");

	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		(record_valid && is_match) |-> (name_size > {27'd0, cfg.target_len}))
		else $error("match reported with name too short");

	a_trailer_len: assert property (@(posedge clk) disable iff (!arst_n)
		(record_valid && is_trailer) |->
			(name_size > 32'(cpio_nes_pkg::TRAILER_LEN)))
		else $error("trailer reported with name too short");

	// entries start on 4-byte boundaries, so data does too unless saturated
	a_offset_align: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid |-> (data_offset[1:0] == 2'd0 || data_offset == 32'hFFFF_FFFF))
		else $error("data offset not aligned");

endmodule
